>>> sv/gda_pkg.sv
// Shared constants, command codes and calendar helpers for the date arithmetic block.
package gda_pkg;

   // Field widths of the request and response beats
   localparam int CMD_W  = 3;
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 15;
   localparam int CNT_W  = 16;
   localparam int DIFF_W = 25;

   // Day-count accumulator: holds a serial day number of a 16-bit year, signed
   localparam int ACC_W = 26;

   // Default year width of the stored date
   localparam int YEAR_BITS_DEF = 15;

   // Register file
   localparam int                CSR_ADDR_W      = 3;
   localparam int                CSR_DATA_W      = 32;
   localparam logic              REG_LATEST_YEAR = 1'b0;
   localparam logic [YEAR_W-1:0] LATEST_YEAR_RST = 15'd2024;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 3'd0;
   localparam logic [CMD_W-1:0] CMD_INC  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DEC  = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ADD  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_SUB  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_DIFF = 3'd5;

   // x divisible by 25 (x < 2^16) iff x * inverse(25) mod 2^16 <= floor((2^16-1)/25)
   localparam logic [15:0] DIV25_INV = 16'd23593;
   localparam logic [15:0] DIV25_LIM = 16'd2621;
   // floor(v/25) for v < 2^15 as (v * ceil(2^19/25)) >> 19
   localparam logic [29:0] DIV25_MUL = 30'd20972;
   localparam int          DIV25_SH  = 19;

   // Saturation bounds of the difference field
   localparam logic signed [ACC_W-1:0] DIFF_HI = ACC_W'((1 <<< (DIFF_W - 1)) - 1);
   localparam logic signed [ACC_W-1:0] DIFF_LO = -DIFF_HI - ACC_W'(1);

   // Leap year: divisible by 4 and not by 100, or divisible by 400
   function automatic logic is_leap(input logic [15:0] y);
      logic [15:0] t;
      logic        by25;
      t    = 16'(y * DIV25_INV);
      by25 = (t <= DIV25_LIM);
      return (y[1:0] == 2'd0) && (!by25 || (y[3:0] == 4'd0));
   endfunction

   // Length of month m; zero for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_days(input logic [MON_W-1:0] m,
                                                   input logic lp);
      logic [DAY_W-1:0] d;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = lp ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

   // Days in a common year before the first of month m
   function automatic logic [8:0] days_before_month(input logic [MON_W-1:0] m);
      logic [8:0] d;
      case (m)
         4'd1:    d = 9'd0;
         4'd2:    d = 9'd31;
         4'd3:    d = 9'd59;
         4'd4:    d = 9'd90;
         4'd5:    d = 9'd120;
         4'd6:    d = 9'd151;
         4'd7:    d = 9'd181;
         4'd8:    d = 9'd212;
         4'd9:    d = 9'd243;
         4'd10:   d = 9'd273;
         4'd11:   d = 9'd304;
         4'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

   // floor(v / 25) by reciprocal multiply
   function automatic logic [14:0] div25(input logic [14:0] v);
      logic [29:0] p;
      p = 30'(v) * DIV25_MUL;
      return 15'(p >> DIV25_SH);
   endfunction

   // Clamp the day difference into the result field
   function automatic logic [DIFF_W-1:0] sat_diff(input logic signed [ACC_W-1:0] a);
      logic [DIFF_W-1:0] r;
      if (a > DIFF_HI) begin
         r = DIFF_W'(DIFF_HI);
      end else if (a < DIFF_LO) begin
         r = DIFF_W'(DIFF_LO);
      end else begin
         r = a[DIFF_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> sv/gregorian_date_arithmetic.sv
// Gregorian date register with load, step, add/subtract days and day difference.
//
// Usage: one command beat on the req_ channel, one result beat on the rsp_ channel.
// A beat is taken when valid is high and stall is low. The block works on one
// command at a time and holds req_stall high until the command has been handed to
// the result register; the result register lets the next command start while the
// previous result waits for the receiver.
// A difference sums two dates of six terms each through one shared adder.
// Increment, decrement, add and subtract walk the date one month per cycle
// through a single adder/compare unit, and pass through a state that refreshes
// the leap flag for each year crossed. A new command is taken only after the
// previous result has been handed over to the result register.
// A stalled receiver holds the result beat; a finished command waits in its last
// state until the result register frees up, and req_stall stays high meanwhile.
// Reset sets the date to 0001-01-01 and latest_year to 2024; no clearing pass.
// latest_year is written over the csr_ port at byte address 0; the user must
// write it only while idle, and the block itself leaves this unchecked.
module gregorian_date_arithmetic #(
   parameter int YEAR_BITS = gda_pkg::YEAR_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // command channel
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [gda_pkg::CMD_W-1:0]             req_cmd,
   input  logic [gda_pkg::DAY_W-1:0]             req_day_in,
   input  logic [gda_pkg::MON_W-1:0]             req_month_in,
   input  logic [gda_pkg::YEAR_W-1:0]            req_year_in,
   input  logic [gda_pkg::CNT_W-1:0]             req_day_count,
   // result channel
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [gda_pkg::DAY_W-1:0]             rsp_day_out,
   output logic [gda_pkg::MON_W-1:0]             rsp_month_out,
   output logic [gda_pkg::YEAR_W-1:0]            rsp_year_out,
   output logic                                  rsp_ok,
   output logic signed [gda_pkg::DIFF_W-1:0]     rsp_day_difference,
   // register port
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [gda_pkg::CSR_ADDR_W-1:0]        csr_paddr,
   input  logic [gda_pkg::CSR_DATA_W-1:0]        csr_pwdata,
   output logic [gda_pkg::CSR_DATA_W-1:0]        csr_prdata,
   output logic                                  csr_pready
);

   localparam logic [YEAR_BITS-1:0] YEAR_MAX   = '1;
   localparam logic [3:0]           DIFF_STEPS = 4'd12;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_LEAP  = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_DIFF  = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]                          state_ff, state_in;
   logic [gda_pkg::CMD_W-1:0]           cmd_ff, cmd_in;
   logic [gda_pkg::DAY_W-1:0]           din_ff, din_in;
   logic [gda_pkg::MON_W-1:0]           min_ff, min_in;
   logic [gda_pkg::YEAR_W-1:0]          yin_ff, yin_in;
   logic [gda_pkg::CNT_W-1:0]           rem_ff, rem_in;
   logic                                sub_ff, sub_in;
   logic [gda_pkg::DAY_W-1:0]           wd_ff, wd_in;
   logic [gda_pkg::MON_W-1:0]           wm_ff, wm_in;
   logic [YEAR_BITS-1:0]                wy_ff, wy_in;
   logic                                leap_ff, leap_in;
   logic [gda_pkg::DAY_W-1:0]           date_day_ff, date_day_in;
   logic [gda_pkg::MON_W-1:0]           date_mon_ff, date_mon_in;
   logic [YEAR_BITS-1:0]                date_year_ff, date_year_in;
   logic                                ok_ff, ok_in;
   logic signed [gda_pkg::ACC_W-1:0]    acc_ff, acc_in;
   logic signed [gda_pkg::ACC_W-1:0]    term_ff, term_in;
   logic [3:0]                          step_ff, step_in;
   logic [gda_pkg::YEAR_W-1:0]          latest_ff, latest_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [gda_pkg::DAY_W-1:0]           rsp_day_ff, rsp_day_in;
   logic [gda_pkg::MON_W-1:0]           rsp_month_ff, rsp_month_in;
   logic [gda_pkg::YEAR_W-1:0]          rsp_year_ff, rsp_year_in;
   logic                                rsp_ok_ff, rsp_ok_in;
   logic [gda_pkg::DIFF_W-1:0]          rsp_diff_ff, rsp_diff_in;

   logic                                csr_wr;
   logic                                op_valid;
   logic                                load_ok;
   logic [gda_pkg::DAY_W-1:0]           cur_dim;
   logic [gda_pkg::DAY_W-1:0]           cur_left;
   logic                                t_op;
   logic [2:0]                          t_idx;
   logic [15:0]                         t_year;
   logic [16:0]                         t_y17;
   logic [gda_pkg::MON_W-1:0]           t_mon;
   logic [gda_pkg::DAY_W-1:0]           t_day;
   logic [gda_pkg::ACC_W-1:0]           t_mag;
   logic                                t_neg;

   // register port: one register, word index in paddr[2]
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr[gda_pkg::CSR_ADDR_W-1:2] == gda_pkg::REG_LATEST_YEAR);
   assign latest_in  = csr_wr ? csr_pwdata[gda_pkg::YEAR_W-1:0] : latest_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[gda_pkg::CSR_ADDR_W-1:2] == gda_pkg::REG_LATEST_YEAR) ?
                       gda_pkg::CSR_DATA_W'(latest_ff) : '0;

   // operand date check, shared by load and difference
   assign op_valid = (din_ff != 5'd0) &&
                     (din_ff <= gda_pkg::month_days(min_ff, gda_pkg::is_leap(16'(yin_ff))));
   assign load_ok  = op_valid && (yin_ff <= latest_ff) && (17'(yin_ff) <= 17'(YEAR_MAX));

   // days left in the working month
   assign cur_dim  = gda_pkg::month_days(wm_ff, leap_ff);
   assign cur_left = cur_dim - wd_ff;

   // difference term unit: stored date in steps 0..5, operand in 6..11
   assign t_op   = (step_ff >= 4'd6);
   assign t_idx  = t_op ? 3'(step_ff - 4'd6) : step_ff[2:0];
   assign t_year = t_op ? 16'(yin_ff) : 16'(date_year_ff);
   assign t_mon  = t_op ? min_ff : date_mon_ff;
   assign t_day  = t_op ? din_ff : date_day_ff;
   assign t_y17  = 17'(t_year);

   always_comb begin
      t_neg = t_op;
      case (t_idx)
         3'd0: t_mag = gda_pkg::ACC_W'(t_year) * gda_pkg::ACC_W'(365);
         3'd1: t_mag = gda_pkg::ACC_W'((t_y17 + 17'd3) >> 2);
         3'd2: begin
            t_mag = gda_pkg::ACC_W'(gda_pkg::div25(15'((t_y17 + 17'd99) >> 2)));
            t_neg = !t_op;
         end
         3'd3: t_mag = gda_pkg::ACC_W'(gda_pkg::div25(15'((t_y17 + 17'd399) >> 4)));
         3'd4: t_mag = gda_pkg::ACC_W'(gda_pkg::days_before_month(t_mon)) +
                       gda_pkg::ACC_W'(gda_pkg::is_leap(t_year) && (t_mon > 4'd2));
         3'd5: t_mag = gda_pkg::ACC_W'(t_day) - gda_pkg::ACC_W'(1);
         default: t_mag = '0;
      endcase
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      din_in       = din_ff;
      min_in       = min_ff;
      yin_in       = yin_ff;
      rem_in       = rem_ff;
      sub_in       = sub_ff;
      wd_in        = wd_ff;
      wm_in        = wm_ff;
      wy_in        = wy_ff;
      leap_in      = leap_ff;
      date_day_in  = date_day_ff;
      date_mon_in  = date_mon_ff;
      date_year_in = date_year_ff;
      ok_in        = ok_ff;
      acc_in       = acc_ff;
      term_in      = term_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_day_in   = rsp_day_ff;
      rsp_month_in = rsp_month_ff;
      rsp_year_in  = rsp_year_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_diff_in  = rsp_diff_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               din_in  = req_day_in;
               min_in  = req_month_in;
               yin_in  = req_year_in;
               rem_in  = ((req_cmd == gda_pkg::CMD_INC) || (req_cmd == gda_pkg::CMD_DEC)) ?
                         16'd1 : req_day_count;
               sub_in  = (req_cmd == gda_pkg::CMD_DEC) || (req_cmd == gda_pkg::CMD_SUB);
               wd_in   = date_day_ff;
               wm_in   = date_mon_ff;
               wy_in   = date_year_ff;
               ok_in   = 1'b0;
               acc_in  = '0;
               step_in = 4'd0;
               state_in = S_CHECK;
            end
         end

         S_CHECK: begin
            case (cmd_ff)
               gda_pkg::CMD_LOAD: begin
                  if (load_ok) begin
                     date_day_in  = din_ff;
                     date_mon_in  = min_ff;
                     date_year_in = YEAR_BITS'(yin_ff);
                     ok_in        = 1'b1;
                  end
                  state_in = S_OUT;
               end
               gda_pkg::CMD_INC, gda_pkg::CMD_DEC, gda_pkg::CMD_ADD, gda_pkg::CMD_SUB: begin
                  state_in = S_LEAP;
               end
               gda_pkg::CMD_DIFF: begin
                  state_in = op_valid ? S_DIFF : S_OUT;
               end
               default: begin
                  state_in = S_OUT;
               end
            endcase
         end

         // refresh the leap flag at the start of a step command and after the working year changed
         S_LEAP: begin
            leap_in  = gda_pkg::is_leap(16'(wy_ff));
            state_in = S_STEP;
         end

         // one month per cycle, with a pass through S_LEAP whenever the year changes
         S_STEP: begin
            if (!sub_ff) begin
               if (rem_ff <= 16'(cur_left)) begin
                  date_day_in  = wd_ff + rem_ff[gda_pkg::DAY_W-1:0];
                  date_mon_in  = wm_ff;
                  date_year_in = wy_ff;
                  ok_in        = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  rem_in = rem_ff - 16'(cur_left) - 16'd1;
                  wd_in  = 5'd1;
                  if (wm_ff == 4'd12) begin
                     if (wy_ff == YEAR_MAX) begin
                        state_in = S_OUT;
                     end else begin
                        wm_in    = 4'd1;
                        wy_in    = wy_ff + YEAR_BITS'(1);
                        state_in = S_LEAP;
                     end
                  end else begin
                     wm_in = wm_ff + 4'd1;
                  end
               end
            end else begin
               if (rem_ff < 16'(wd_ff)) begin
                  date_day_in  = wd_ff - rem_ff[gda_pkg::DAY_W-1:0];
                  date_mon_in  = wm_ff;
                  date_year_in = wy_ff;
                  ok_in        = 1'b1;
                  state_in     = S_OUT;
               end else begin
                  rem_in = rem_ff - 16'(wd_ff);
                  if (wm_ff == 4'd1) begin
                     if (wy_ff == '0) begin
                        state_in = S_OUT;
                     end else begin
                        wm_in    = 4'd12;
                        wd_in    = 5'd31;
                        wy_in    = wy_ff - YEAR_BITS'(1);
                        state_in = S_LEAP;
                     end
                  end else begin
                     wm_in = wm_ff - 4'd1;
                     wd_in = gda_pkg::month_days(wm_ff - 4'd1, leap_ff);
                  end
               end
            end
         end

         // form a term into term_ff and add it to the accumulator in the following cycle
         S_DIFF: begin
            if (step_ff != DIFF_STEPS) begin
               term_in = t_neg ? $signed(-t_mag) : $signed(t_mag);
            end
            if (step_ff != 4'd0) begin
               acc_in = acc_ff + term_ff;
            end
            if (step_ff == DIFF_STEPS) begin
               ok_in    = 1'b1;
               state_in = S_OUT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end

         // hand the result to the output register once it is free
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_day_in   = date_day_ff;
               rsp_month_in = date_mon_ff;
               rsp_year_in  = gda_pkg::YEAR_W'(date_year_ff);
               rsp_ok_in    = ok_ff;
               rsp_diff_in  = gda_pkg::sat_diff(acc_ff);
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state and stored date
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         date_day_ff  <= 5'd1;
         date_mon_ff  <= 4'd1;
         date_year_ff <= YEAR_BITS'(1);
         latest_ff    <= gda_pkg::LATEST_YEAR_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         date_day_ff  <= date_day_in;
         date_mon_ff  <= date_mon_in;
         date_year_ff <= date_year_in;
         latest_ff    <= latest_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      din_ff       <= din_in;
      min_ff       <= min_in;
      yin_ff       <= yin_in;
      rem_ff       <= rem_in;
      sub_ff       <= sub_in;
      wd_ff        <= wd_in;
      wm_ff        <= wm_in;
      wy_ff        <= wy_in;
      leap_ff      <= leap_in;
      ok_ff        <= ok_in;
      acc_ff       <= acc_in;
      term_ff      <= term_in;
      step_ff      <= step_in;
      rsp_day_ff   <= rsp_day_in;
      rsp_month_ff <= rsp_month_in;
      rsp_year_ff  <= rsp_year_in;
      rsp_ok_ff    <= rsp_ok_in;
      rsp_diff_ff  <= rsp_diff_in;
   end

   assign req_stall          = (state_ff != S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_day_out        = rsp_day_ff;
   assign rsp_month_out      = rsp_month_ff;
   assign rsp_year_out       = rsp_year_ff;
   assign rsp_ok             = rsp_ok_ff;
   assign rsp_day_difference = $signed(rsp_diff_ff);

`ifndef ASSERT_OFF
   // stored date is always a real calendar date
   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      (date_mon_ff >= 4'd1) && (date_mon_ff <= 4'd12) && (date_day_ff != 5'd0) &&
      (date_day_ff <= gda_pkg::month_days(date_mon_ff, gda_pkg::is_leap(16'(date_year_ff)))))
      else $error("stored date out of calendar");

   // the date only changes while a command is in work
   a_idle_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |=> ($stable(date_day_ff) && $stable(date_mon_ff) &&
                                $stable(date_year_ff)))
      else $error("date changed while idle");

   // the remaining day count never grows while stepping
   a_rem_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |=> (rem_ff <= $past(rem_ff)))
      else $error("remaining day count grew");

   // a refused command reports no difference
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_diff_ff == '0))
      else $error("difference reported on refused command");
`endif

endmodule
